>>> design/fpa_pkg.sv
// ----------------------------------------------------------------------------
// fpa_pkg: shared definitions of the fixed-point ALU
// Opcodes, status codes and default sizes used by the ALU pipeline.
// ----------------------------------------------------------------------------
package fpa_pkg;

   localparam int FRAC_BITS_DEFAULT = 8;
   localparam int WORD_BITS_DEFAULT = 32;

   typedef enum logic [3:0] {
      OP_ADD      = 4'd0,
      OP_SUB      = 4'd1,
      OP_MUL      = 4'd2,
      OP_DIV      = 4'd3,
      OP_LT       = 4'd4,
      OP_LE       = 4'd5,
      OP_GT       = 4'd6,
      OP_GE       = 4'd7,
      OP_EQ       = 4'd8,
      OP_NE       = 4'd9,
      OP_MIN      = 4'd10,
      OP_MAX      = 4'd11,
      OP_INC      = 4'd12,
      OP_DEC      = 4'd13,
      OP_FROM_INT = 4'd14,
      OP_TO_INT   = 4'd15
   } op_type;

   typedef logic [1:0] status_type;

   localparam status_type ST_OK      = 2'd0;
   localparam status_type ST_DIVZERO = 2'd1;
   localparam status_type ST_SAT     = 2'd2;

endpackage

>>> design/fixed_point_alu.sv
// ----------------------------------------------------------------------------
// fixed_point_alu: pipelined signed fixed-point ALU
// Add, subtract, multiply, divide, compare, min/max and conversions on raw
// two's-complement words, with saturation and rounding to nearest.
// ----------------------------------------------------------------------------
// Usage
// The request channel carries one operation per transfer: the opcode in
// req_tuser and the two raw operands in req_tdata. The response channel
// returns one transfer per request, in request order: the raw result in
// rsp_tdata and the compare flag and status in rsp_tuser.
// Every operation takes the same path through the pipeline (stage 1,
// stage 2, stage 3, the divider chain and the output stage), so the
// latency does not depend on the opcode. The divider sets the length: it
// resolves W + F quotient bits (40 at the default Q24.8 sizes), one per stage.
// Throughput is one operation per cycle for any mix of opcodes while the receiver does not stall.
// Reset clears the valid bit of every stage; no data is lost other than
// operations already in flight. When the receiver stalls with a response
// waiting, the whole pipeline holds and req_tready falls; nothing is dropped
// or repeated, and bubbles inside the pipeline stay where they are until
// the output moves again.
// ----------------------------------------------------------------------------
module fixed_point_alu #(
   parameter int FRAC_BITS = fpa_pkg::FRAC_BITS_DEFAULT,
   parameter int WORD_BITS = fpa_pkg::WORD_BITS_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,   // [31:0] operand_a, [63:32] operand_b
   input  logic [3:0]  req_tuser,   // [3:0] opcode
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [31:0] result_raw
   output logic [2:0]  rsp_tuser    // [0] compare_true, [2:1] status
);
   import fpa_pkg::*;

   // The datapath word is at most 32 bits, the width of the operand fields.
   localparam int W  = (WORD_BITS < 32) ? WORD_BITS : 32;
   localparam int F  = FRAC_BITS;
   // Quotient bits: the numerator is the operand magnitude shifted up by F.
   localparam int NB = W + F;

   localparam logic [63:0] LIM_U = 64'(1) << (W - 1);
   localparam longint      MAXV  = (longint'(1) <<< (W - 1)) - 1;
   localparam longint      MINV  = -(longint'(1) <<< (W - 1));
   localparam logic [63:0] HALF  = 64'(1) << (F - 1);
   localparam longint      FMASK = (longint'(1) <<< F) - 1;

   // Sign and magnitude back to a word, saturating. Returns {sat, value}.
   function automatic logic [32:0] from_mag(input logic neg, input logic [63:0] mag);
      logic [32:0] res;
      if (neg) begin
         if (mag > LIM_U) res = {1'b1, 32'(MINV)};
         else             res = {1'b0, 32'(64'(0) - mag)};
      end else begin
         if (mag > LIM_U - 64'(1)) res = {1'b1, 32'(MAXV)};
         else                      res = {1'b0, mag[31:0]};
      end
      return res;
   endfunction

   function automatic logic [32:0] clamp(input longint v);
      logic [32:0] res;
      if (v > MAXV)      res = {1'b1, 32'(MAXV)};
      else if (v < MINV) res = {1'b1, 32'(MINV)};
      else               res = {1'b0, 32'(v)};
      return res;
   endfunction

   // The whole pipeline advances together whenever the output can move.
   logic advance;
   logic out_valid_ff;
   assign advance    = !out_valid_ff || rsp_tready;
   assign req_tready = advance;

   // ---------------- Stage 1: operands taken in, magnitudes formed ----------
   logic signed [W-1:0] a_w, b_w;
   longint              a_l, b_l;
   logic [63:0]         ma_l, mb_l;

   assign a_w  = $signed(req_tdata[W-1:0]);
   assign b_w  = $signed(req_tdata[32+W-1:32]);
   assign a_l  = longint'(a_w);
   assign b_l  = longint'(b_w);
   assign ma_l = (a_l < 0) ? 64'(-a_l) : 64'(a_l);
   assign mb_l = (b_l < 0) ? 64'(-b_l) : 64'(b_l);

   logic                s1_valid_ff;
   op_type              s1_op_ff;
   logic signed [W-1:0] s1_a_ff, s1_b_ff;
   logic [W-1:0]        s1_ma_ff, s1_mb_ff;
   logic                s1_neg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= req_tvalid;
      end
      if (advance) begin
         s1_op_ff  <= op_type'(req_tuser);
         s1_a_ff   <= a_w;
         s1_b_ff   <= b_w;
         s1_ma_ff  <= ma_l[W-1:0];
         s1_mb_ff  <= mb_l[W-1:0];
         s1_neg_ff <= a_w[W-1] ^ b_w[W-1];
      end
   end

   // ---------------- Stage 2: product and the simple operations ------------
   longint      x_a, x_b;
   logic [32:0] simple_sr;
   logic        simple_cmp;
   logic [31:0] simple_res_in;
   status_type  simple_st_in;

   assign x_a = longint'(s1_a_ff);
   assign x_b = longint'(s1_b_ff);

   always_comb begin
      simple_sr  = 33'd0;
      simple_cmp = 1'b0;
      case (s1_op_ff)
         OP_ADD:      simple_sr = clamp(x_a + x_b);
         OP_SUB:      simple_sr = clamp(x_a - x_b);
         OP_LT:       simple_cmp = (x_a < x_b);
         OP_LE:       simple_cmp = (x_a <= x_b);
         OP_GT:       simple_cmp = (x_a > x_b);
         OP_GE:       simple_cmp = (x_a >= x_b);
         OP_EQ:       simple_cmp = (x_a == x_b);
         OP_NE:       simple_cmp = (x_a != x_b);
         OP_MIN:      simple_sr = {1'b0, 32'((x_a <= x_b) ? x_a : x_b)};
         OP_MAX:      simple_sr = {1'b0, 32'((x_a >= x_b) ? x_a : x_b)};
         OP_INC:      simple_sr = clamp(x_a + 1);
         OP_DEC:      simple_sr = clamp(x_a - 1);
         OP_FROM_INT: simple_sr = from_mag(s1_a_ff[W-1], 64'(s1_ma_ff) << F);
         // Truncation toward zero: negative values are biased up before the shift.
         OP_TO_INT:   simple_sr = {1'b0,
                         32'(((x_a < 0) ? (x_a + FMASK) : x_a) >>> F)};
         default:     simple_sr = 33'd0;   // multiply and divide finish later
      endcase
      simple_res_in = simple_sr[31:0];
      simple_st_in  = simple_sr[32] ? ST_SAT : ST_OK;
   end

   logic               s2_valid_ff;
   op_type             s2_op_ff;
   logic               s2_neg_ff;
   logic [2*W-1:0]     s2_prod_ff;
   logic [31:0]        s2_res_ff;
   logic               s2_cmp_ff;
   status_type         s2_st_ff;
   logic [W-1:0]       s2_d_ff;
   logic [NB-1:0]      s2_n_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (advance) begin
         s2_valid_ff <= s1_valid_ff;
      end
      if (advance) begin
         s2_op_ff   <= s1_op_ff;
         s2_neg_ff  <= s1_neg_ff;
         s2_prod_ff <= (2*W)'(s1_ma_ff) * (2*W)'(s1_mb_ff);
         s2_res_ff  <= simple_res_in;
         s2_cmp_ff  <= simple_cmp;
         s2_st_ff   <= simple_st_in;
         s2_d_ff    <= s1_mb_ff;
         s2_n_ff    <= {s1_ma_ff, {F{1'b0}}};
      end
   end

   // ---------------- Stage 3: product rounded and saturated ----------------
   logic [63:0] mul_mag;
   logic [32:0] mul_sr;
   assign mul_mag = (64'(s2_prod_ff) + HALF) >> F;
   assign mul_sr  = from_mag(s2_neg_ff, mul_mag);

   // Divider chain: entry 0 is stage 3, entry k+1 follows quotient bit k.
   logic              dv_ff   [NB+1];
   op_type            dop_ff  [NB+1];
   logic              dneg_ff [NB+1];
   logic [31:0]       dres_ff [NB+1];
   logic              dcmp_ff [NB+1];
   status_type        dst_ff  [NB+1];
   logic [W-1:0]      dd_ff   [NB+1];
   logic [W-1:0]      drem_ff [NB+1];
   logic [NB-1:0]     dn_ff   [NB+1];
   logic [NB-1:0]     dq_ff   [NB+1];

   always_ff @(posedge clock) begin
      if (reset) begin
         dv_ff[0] <= 1'b0;
      end else if (advance) begin
         dv_ff[0] <= s2_valid_ff;
      end
      if (advance) begin
         dop_ff[0]  <= s2_op_ff;
         dneg_ff[0] <= s2_neg_ff;
         dcmp_ff[0] <= s2_cmp_ff;
         dd_ff[0]   <= s2_d_ff;
         drem_ff[0] <= '0;
         dn_ff[0]   <= s2_n_ff;
         dq_ff[0]   <= '0;
         if (s2_op_ff == OP_MUL) begin
            dres_ff[0] <= mul_sr[31:0];
            dst_ff[0]  <= mul_sr[32] ? ST_SAT : ST_OK;
         end else begin
            dres_ff[0] <= s2_res_ff;
            dst_ff[0]  <= s2_st_ff;
         end
      end
   end

   // Restoring division, one quotient bit per stage.
   for (genvar k = 0; k < NB; k++) begin : g_div
      logic [W:0]    trial;
      logic          ge;
      logic [W-1:0]  rem_in;
      logic [NB-1:0] q_in;

      assign trial  = {drem_ff[k], dn_ff[k][NB-1]};
      assign ge     = (trial >= {1'b0, dd_ff[k]});
      assign rem_in = ge ? W'(trial - {1'b0, dd_ff[k]}) : trial[W-1:0];
      assign q_in   = {dq_ff[k][NB-2:0], ge};

      always_ff @(posedge clock) begin
         if (reset) begin
            dv_ff[k+1] <= 1'b0;
         end else if (advance) begin
            dv_ff[k+1] <= dv_ff[k];
         end
         if (advance) begin
            dop_ff[k+1]  <= dop_ff[k];
            dneg_ff[k+1] <= dneg_ff[k];
            dres_ff[k+1] <= dres_ff[k];
            dcmp_ff[k+1] <= dcmp_ff[k];
            dst_ff[k+1]  <= dst_ff[k];
            dd_ff[k+1]   <= dd_ff[k];
            drem_ff[k+1] <= rem_in;
            dn_ff[k+1]   <= dn_ff[k] << 1;
            dq_ff[k+1]   <= q_in;
         end
      end
   end

   // ---------------- Output stage: quotient rounded, result registered -----
   logic        round_up;
   logic [32:0] div_sr;
   logic [31:0] out_res_in;
   status_type  out_st_in;

   // Round half away from zero: bump when twice the remainder reaches the divisor.
   assign round_up = ({drem_ff[NB], 1'b0} >= {1'b0, dd_ff[NB]});
   assign div_sr   = from_mag(dneg_ff[NB], 64'(dq_ff[NB]) + 64'(round_up));

   always_comb begin
      out_res_in = dres_ff[NB];
      out_st_in  = dst_ff[NB];
      if (dop_ff[NB] == OP_DIV) begin
         if (dd_ff[NB] == '0) begin
            out_res_in = 32'd0;
            out_st_in  = ST_DIVZERO;
         end else begin
            out_res_in = div_sr[31:0];
            out_st_in  = div_sr[32] ? ST_SAT : ST_OK;
         end
      end
   end

   logic [31:0] out_res_ff;
   logic        out_cmp_ff;
   status_type  out_st_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= dv_ff[NB];
      end
      if (advance) begin
         out_res_ff <= out_res_in;
         out_cmp_ff <= dcmp_ff[NB];
         out_st_ff  <= out_st_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_res_ff;
   assign rsp_tuser  = {out_st_ff, out_cmp_ff};

endmodule

>>> sim/tb_fixed_point_alu.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_fixed_point_alu: self-checking bench for the fixed-point ALU
// Drives directed corner operations and then random operations through the
// request stream. A scoreboard predicts each response from the operands and
// compares every response transfer, field by field, with the oldest
// prediction. Both sides idle at random, and the receiver once holds off for
// a long stretch so that the pipeline fills up and stalls its input.
// ----------------------------------------------------------------------------
module tb_fixed_point_alu;
   import fpa_pkg::*;

   localparam int FRAC = FRAC_BITS_DEFAULT;
   localparam int LATENCY = 32 + FRAC + 4;
   localparam int RANDOM_OPS = 1800;

   // One predicted response.
   typedef struct packed {
      logic [31:0] result_raw;
      logic        compare_true;
      status_type  status;
   } alu_result_type;

   // Predicts ALU results and holds those still outstanding.
   class alu_scoreboard;
      alu_result_type pending[$];
      int             mismatches;

      // Clamps a sign and a magnitude into the 32-bit signed range.
      function automatic logic [31:0] signed_from_mag(bit neg, logic [63:0] mag,
                                                      inout status_type st);
         if (neg) begin
            if (mag > 64'h8000_0000) begin
               st = ST_SAT;
               return 32'h8000_0000;
            end
            return 32'(-mag);
         end
         if (mag > 64'h7FFF_FFFF) begin
            st = ST_SAT;
            return 32'h7FFF_FFFF;
         end
         return mag[31:0];
      endfunction

      function automatic logic [31:0] clamp_sum(longint v, inout status_type st);
         if (v > 64'sh7FFF_FFFF) begin
            st = ST_SAT;
            return 32'h7FFF_FFFF;
         end
         if (v < -64'sh8000_0000) begin
            st = ST_SAT;
            return 32'h8000_0000;
         end
         return v[31:0];
      endfunction

      // Notes an accepted request and works out its response.
      function void note_request(op_type op, logic [31:0] a_bits, logic [31:0] b_bits);
         longint         a, b;
         logic [63:0]    ma, mb, m, q, rm;
         alu_result_type r;
         a = longint'($signed(a_bits));
         b = longint'($signed(b_bits));
         ma = a < 0 ? -a : a;
         mb = b < 0 ? -b : b;
         r = '0;
         r.status = ST_OK;
         case (op)
            OP_ADD: r.result_raw = clamp_sum(a + b, r.status);
            OP_SUB: r.result_raw = clamp_sum(a - b, r.status);
            OP_MUL: begin
               m = (ma * mb + (64'd1 << (FRAC - 1))) >> FRAC;
               r.result_raw = signed_from_mag((a < 0) != (b < 0), m, r.status);
            end
            OP_DIV: begin
               if (mb == 0) begin
                  r.status = ST_DIVZERO;
               end else begin
                  q = (ma << FRAC) / mb;
                  rm = (ma << FRAC) % mb;
                  if (rm >= mb - rm) q++;
                  r.result_raw = signed_from_mag((a < 0) != (b < 0), q, r.status);
               end
            end
            OP_LT: r.compare_true = a < b;
            OP_LE: r.compare_true = a <= b;
            OP_GT: r.compare_true = a > b;
            OP_GE: r.compare_true = a >= b;
            OP_EQ: r.compare_true = a == b;
            OP_NE: r.compare_true = a != b;
            OP_MIN: r.result_raw = (a <= b) ? a_bits : b_bits;
            OP_MAX: r.result_raw = (a >= b) ? a_bits : b_bits;
            OP_INC: r.result_raw = clamp_sum(a + 1, r.status);
            OP_DEC: r.result_raw = clamp_sum(a - 1, r.status);
            OP_FROM_INT: r.result_raw = signed_from_mag(a < 0, ma << FRAC, r.status);
            default: r.result_raw = 32'(a / (64'sd1 <<< FRAC));
         endcase
         pending.push_back(r);
      endfunction

      // Checks one response transfer against the oldest prediction.
      function void check_response(logic [31:0] res, logic cmp, status_type st);
         alu_result_type want;
         if (pending.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("Unexpected response: result %h cmp %b status %0d", res, cmp, st);
            return;
         end
         want = pending.pop_front();
         if (res !== want.result_raw || cmp !== want.compare_true
             || st !== want.status) begin
            mismatches++;
            if (mismatches <= 10)
               $display("Mismatch: expected %h/%b/%0d, got %h/%b/%0d",
                        want.result_raw, want.compare_true, want.status, res, cmp, st);
         end
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [63:0] req_tdata = '0;
   logic [3:0]  req_tuser = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;
   logic [2:0]  rsp_tuser;

   alu_scoreboard board = new();
   bit            idle_free;        // a stretch with no idling on either side
   bit            hold_off_now;     // receiver forced to stall
   bit            sending_done;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   fixed_point_alu dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser)
   );

   // Every transfer on both sides is seen at the rising edge, before the new
   // drive values of that edge take effect.
   always @(posedge clock) begin
      if (!reset && req_tvalid && req_tready)
         board.note_request(op_type'(req_tuser), req_tdata[31:0], req_tdata[63:32]);
      if (!reset && rsp_tvalid && rsp_tready)
         board.check_response(rsp_tdata, rsp_tuser[0], status_type'(rsp_tuser[2:1]));
   end

   // Receiver: random stalls, except during the free stretch or a hold-off.
   always @(posedge clock) begin
      if (hold_off_now)
         rsp_tready <= 1'b0;
      else
         rsp_tready <= idle_free || ($urandom_range(99) >= 27);
   end

   // Long hold-off, counted in cycles, so that the pipeline fills and
   // req_tready falls while the sender keeps offering operations.
   initial begin
      repeat (12 + 400) @(posedge clock);
      hold_off_now = 1'b1;
      repeat (300) @(posedge clock);
      hold_off_now = 1'b0;
   end

   // Offers one operation and waits for its transfer, with a random gap first.
   task automatic send_op(op_type op, logic [31:0] a, logic [31:0] b);
      while (!idle_free && $urandom_range(99) < 27) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= op;
      req_tdata <= {b, a};
      do @(posedge clock); while (!req_tready);
   endtask

   function automatic logic [31:0] random_operand();
      case ($urandom_range(4))
         0: return $urandom;
         1: return 32'($signed($urandom_range(2000)) - 1000);
         2: return $urandom_range(1) ? 32'h7FFF_FFFF - $urandom_range(3)
                                      : 32'h8000_0000 + $urandom_range(3);
         3: return 32'($signed($urandom_range(1 << 16)) - (1 << 15)) << FRAC;
         default: return $urandom >> $urandom_range(31);
      endcase
   endfunction

   initial begin
      int          i;
      logic [31:0] a, b;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: every operation at the extremes and the named special cases.
      for (i = 0; i < 16; i++)
         send_op(op_type'(i), 32'h7FFF_FFFF, 32'h8000_0000);
      send_op(OP_DIV, 32'h0000_0100, 32'h0);             // divide by zero
      send_op(OP_MUL, 32'h8000_0000, 32'h8000_0000);     // multiply overflow
      send_op(OP_DIV, 32'h0000_0001, 32'h0000_0002);     // exact quotient, no rounding
      send_op(OP_MIN, 32'hFFFF_FF00, 32'hFFFF_FF00);     // tie on min
      send_op(OP_MAX, 32'h0000_0500, 32'h0000_0500);     // tie on max
      send_op(OP_TO_INT, 32'hFFFF_FF01, 32'h0);          // truncation toward zero
      send_op(OP_FROM_INT, 32'hFF80_0000, 32'h0);        // exact lower limit
      send_op(OP_INC, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
      send_op(OP_DEC, 32'h8000_0000, 32'h0);

      for (i = 0; i < RANDOM_OPS; i++) begin
         idle_free = (i >= 1000 && i < 1200);
         a = random_operand();
         b = ($urandom_range(15) == 0) ? 32'h0 : random_operand();
         send_op(op_type'($urandom_range(15)), a, b);
      end
      idle_free = 1'b0;
      req_tvalid <= 1'b0;
      sending_done = 1'b1;
   end

   initial begin
      wait (sending_done);
      while (board.pending.size() != 0) @(posedge clock);
      repeat (LATENCY + 20) @(posedge clock);
      if (board.mismatches == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

   // Watchdog, far beyond the slowest correct run.
   initial begin
      #2_000_000;
      $display("CHECKS FAILED");
      $finish;
   end
endmodule

>>> sim.f
design/fpa_pkg.sv
design/fixed_point_alu.sv
sim/tb_fixed_point_alu.sv
